// ===== hw/rtl/asnf32_pkg.sv =====
// Package for the approximate square root unit: float32 constants,
// field helpers and the shared normalize-and-round function.
// No dependencies.
package asnf32_pkg;

  localparam logic [31:0] MAGIC_SEED        = 32'h5F3759DF;
  localparam logic [31:0] BITS_HALF         = 32'h3F000000;
  localparam logic [31:0] BITS_THREE_HALVES = 32'h3FC00000;
  localparam logic [31:0] BITS_QNAN         = 32'h7FC00000;
  localparam logic [31:0] BITS_INF          = 32'h7F800000;
  localparam int          NUM_STAGES        = 12;

  typedef struct packed {
    logic s1;
    logic s2;
  } stage_ce_t;

  function automatic logic is_nan(input logic [31:0] b);
    return b[30:0] > BITS_INF[30:0];
  endfunction

  function automatic logic is_inf(input logic [31:0] b);
    return b[30:0] == BITS_INF[30:0];
  endfunction

  function automatic logic is_zero(input logic [31:0] b);
    return b[30:0] == 31'd0;
  endfunction

  function automatic logic [23:0] sig_of(input logic [31:0] b);
    return (b[30:23] != 8'd0) ? {1'b1, b[22:0]} : {1'b0, b[22:0]};
  endfunction

  function automatic logic signed [11:0] scale_of(input logic [31:0] b);
    return (b[30:23] != 8'd0) ? $signed({4'd0, b[30:23]}) - 12'sd150 : -12'sd149;
  endfunction

  function automatic logic [5:0] msb_index(input logic [63:0] v);
    logic [5:0] idx;
    idx = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) begin
        idx = 6'(i);
      end
    end
    return idx;
  endfunction

  // Rounds sign * sig * 2^scale to float32, nearest even, with subnormals.
  function automatic logic [31:0] round_pack(input logic sgn,
                                             input logic signed [11:0] scale,
                                             input logic [63:0] sig);
    logic [5:0]         p;
    logic [63:0]        n;
    logic signed [11:0] e;
    logic signed [11:0] sh;
    logic [31:0]        field;
    logic [31:0]        mant;
    logic               rnd;
    logic               sticky;
    logic [63:0]        tmp;
    logic [31:0]        bits;
    p      = msb_index(sig);
    n      = sig << (6'd63 - p);
    e      = scale + $signed({6'd0, p}) + 12'sd127;
    field  = 32'd0;
    mant   = 32'd0;
    rnd    = 1'b0;
    sticky = 1'b0;
    sh     = 12'sd40;
    if (e >= 12'sd1) begin
      field = {1'b0, 8'(e - 12'sd1), 23'd0};
    end else begin
      sh = 12'sd41 - e;
    end
    if (sh >= 12'sd65) begin
      sticky = 1'b1;
    end else begin
      mant   = 32'(n >> 7'(sh));
      tmp    = n >> 7'(sh - 12'sd1);
      rnd    = tmp[0];
      sticky = (n << 7'(12'sd65 - sh)) != 64'd0;
    end
    bits = field + mant;
    if (rnd && (sticky || mant[0])) begin
      bits = bits + 32'd1;
    end
    if (bits >= BITS_INF) begin
      bits = BITS_INF;
    end
    if (sig == 64'd0) begin
      return {sgn, 31'd0};
    end else if (e >= 12'sd255) begin
      return {sgn, BITS_INF[30:0]};
    end
    return {sgn, bits[30:0]};
  endfunction

endpackage

// ===== hw/rtl/asnf32_stream_if.sv =====
// Valid/ready channel interfaces for the input item and the result item.
// Standalone; no package needed.
interface asnf32_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] value_bits;
  modport source (output valid, output value_bits, input ready);
  modport sink (input valid, input value_bits, output ready);
endinterface

interface asnf32_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] root_bits;
  modport source (output valid, output root_bits, input ready);
  modport sink (input valid, input root_bits, output ready);
endinterface

// ===== hw/rtl/asnf32_fmul.sv =====
// Two-stage float32 multiplier: significand product, then normalize and round.
// Uses asnf32_pkg.
module asnf32_fmul (
  input  logic                  clk,
  input  asnf32_pkg::stage_ce_t ce,
  input  logic [31:0]           a,
  input  logic [31:0]           b,
  output logic [31:0]           result
);

  logic                sgn_r;
  logic signed [11:0]  scale_r;
  logic [47:0]         prod_r;
  logic                spec_r;
  logic [31:0]         spec_val_r;
  logic [31:0]         result_r;
  logic                sgn_nxt;
  logic                spec_nxt;
  logic [31:0]         spec_val_nxt;

  always_comb begin
    sgn_nxt      = a[31] ^ b[31];
    spec_nxt     = 1'b1;
    spec_val_nxt = {sgn_nxt, 31'd0};
    if (asnf32_pkg::is_nan(a) || asnf32_pkg::is_nan(b)) begin
      spec_val_nxt = asnf32_pkg::BITS_QNAN;
    end else if (asnf32_pkg::is_inf(a) || asnf32_pkg::is_inf(b)) begin
      if (asnf32_pkg::is_zero(a) || asnf32_pkg::is_zero(b)) begin
        spec_val_nxt = asnf32_pkg::BITS_QNAN;
      end else begin
        spec_val_nxt = {sgn_nxt, asnf32_pkg::BITS_INF[30:0]};
      end
    end else if (!(asnf32_pkg::is_zero(a) || asnf32_pkg::is_zero(b))) begin
      spec_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ce.s1) begin
      sgn_r      <= sgn_nxt;
      scale_r    <= asnf32_pkg::scale_of(a) + asnf32_pkg::scale_of(b);
      prod_r     <= asnf32_pkg::sig_of(a) * asnf32_pkg::sig_of(b);
      spec_r     <= spec_nxt;
      spec_val_r <= spec_val_nxt;
    end
    if (ce.s2) begin
      result_r <= spec_r ? spec_val_r
                         : asnf32_pkg::round_pack(sgn_r, scale_r, {16'd0, prod_r});
    end
  end

  assign result = result_r;

endmodule

// ===== hw/rtl/asnf32_fadd.sv =====
// Two-stage float32 adder: align and add, then normalize and round.
// Uses asnf32_pkg.
module asnf32_fadd (
  input  logic                  clk,
  input  asnf32_pkg::stage_ce_t ce,
  input  logic [31:0]           a,
  input  logic [31:0]           b,
  output logic [31:0]           result
);

  logic                sgn_r;
  logic signed [11:0]  scale_r;
  logic [50:0]         mag_r;
  logic                spec_r;
  logic [31:0]         spec_val_r;
  logic [31:0]         result_r;

  logic                sgn_nxt;
  logic signed [11:0]  scale_nxt;
  logic [50:0]         mag_nxt;
  logic                spec_nxt;
  logic [31:0]         spec_val_nxt;
  logic [31:0]         hi;
  logic [31:0]         lo;
  logic signed [11:0]  sa;
  logic signed [11:0]  sb;
  logic [8:0]          diff;
  logic [49:0]         va;
  logic [49:0]         vb;
  logic [49:0]         full;

  always_comb begin
    sa = asnf32_pkg::scale_of(a);
    sb = asnf32_pkg::scale_of(b);
    if (sa < sb) begin
      hi = b;
      lo = a;
    end else begin
      hi = a;
      lo = b;
    end
    diff      = 9'(asnf32_pkg::scale_of(hi) - asnf32_pkg::scale_of(lo));
    scale_nxt = asnf32_pkg::scale_of(hi) - 12'sd26;
    va        = {asnf32_pkg::sig_of(hi), 26'd0};
    full      = {asnf32_pkg::sig_of(lo), 26'd0};
    if (diff >= 9'd50) begin
      vb = 50'd1;
    end else begin
      vb = (full >> diff) | {49'd0, ((full << (9'd50 - diff)) != 50'd0)};
    end
    sgn_nxt      = hi[31];
    mag_nxt      = 51'd0;
    spec_nxt     = 1'b0;
    spec_val_nxt = 32'd0;
    if (hi[31] == lo[31]) begin
      mag_nxt = {1'b0, va} + {1'b0, vb};
    end else if (va > vb) begin
      mag_nxt = {1'b0, va - vb};
    end else if (vb > va) begin
      mag_nxt = {1'b0, vb - va};
      sgn_nxt = lo[31];
    end else begin
      spec_nxt = 1'b1;
    end
    if (asnf32_pkg::is_nan(a) || asnf32_pkg::is_nan(b)) begin
      spec_nxt     = 1'b1;
      spec_val_nxt = asnf32_pkg::BITS_QNAN;
    end else if (asnf32_pkg::is_inf(a) && asnf32_pkg::is_inf(b)) begin
      spec_nxt     = 1'b1;
      spec_val_nxt = (a[31] != b[31]) ? asnf32_pkg::BITS_QNAN : a;
    end else if (asnf32_pkg::is_inf(a)) begin
      spec_nxt     = 1'b1;
      spec_val_nxt = a;
    end else if (asnf32_pkg::is_inf(b)) begin
      spec_nxt     = 1'b1;
      spec_val_nxt = b;
    end else if (asnf32_pkg::is_zero(a)) begin
      spec_nxt     = 1'b1;
      spec_val_nxt = asnf32_pkg::is_zero(b) ? {a[31] & b[31], 31'd0} : b;
    end else if (asnf32_pkg::is_zero(b)) begin
      spec_nxt     = 1'b1;
      spec_val_nxt = a;
    end
  end

  always_ff @(posedge clk) begin
    if (ce.s1) begin
      sgn_r      <= sgn_nxt;
      scale_r    <= scale_nxt;
      mag_r      <= mag_nxt;
      spec_r     <= spec_nxt;
      spec_val_r <= spec_val_nxt;
    end
    if (ce.s2) begin
      result_r <= spec_r ? spec_val_r
                         : asnf32_pkg::round_pack(sgn_r, scale_r, {13'd0, mag_r});
    end
  end

  assign result = result_r;

endmodule

// ===== hw/rtl/approx_sqrt_newton_float32_unit.sv =====
// Approximate float32 square root: magic seed, one Newton step, times input.
// Throughput one item per cycle while out_s.ready is high, set by six 2-stage units.
// Each stage advances when empty or when the stage after it advances.
// Reset (rst_n, synchronous, active low) clears all stage valid bits.
// Uses asnf32_pkg, asnf32_stream_if, asnf32_fmul and asnf32_fadd.
module approx_sqrt_newton_float32_unit (
  input  logic               clk,
  input  logic               rst_n,
  asnf32_in_if.sink          in_s,
  asnf32_out_if.source       out_s
);

  localparam int N = asnf32_pkg::NUM_STAGES;

  logic [N-1:0] valid_r;
  logic [N:0]   ce;
  logic [31:0]  x_r  [10];
  logic [31:0]  y0_r [8];
  logic [31:0]  seed;
  logic [31:0]  half_w;
  logic [31:0]  p_w;
  logic [31:0]  t_w;
  logic [31:0]  s_w;
  logic [31:0]  y_w;
  logic [31:0]  r_w;

  assign ce[N] = out_s.ready;
  for (genvar k = 0; k < N; k++) begin : g_ce
    assign ce[k] = !valid_r[k] || ce[k+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (ce[0]) begin
        valid_r[0] <= in_s.valid;
      end
      for (int k = 1; k < N; k++) begin
        if (ce[k]) begin
          valid_r[k] <= valid_r[k-1];
        end
      end
    end
  end

  assign seed = asnf32_pkg::MAGIC_SEED - {in_s.value_bits[31], in_s.value_bits[31:1]};

  always_ff @(posedge clk) begin
    if (ce[0]) begin
      x_r[0]  <= in_s.value_bits;
      y0_r[0] <= seed;
    end
    for (int k = 1; k < 10; k++) begin
      if (ce[k]) begin
        x_r[k] <= x_r[k-1];
      end
    end
    for (int k = 1; k < 8; k++) begin
      if (ce[k]) begin
        y0_r[k] <= y0_r[k-1];
      end
    end
  end

  asnf32_fmul u_half (
    .clk, .ce({ce[0], ce[1]}),
    .a(asnf32_pkg::BITS_HALF), .b(in_s.value_bits), .result(half_w)
  );

  asnf32_fmul u_p (
    .clk, .ce({ce[2], ce[3]}),
    .a(half_w), .b(y0_r[1]), .result(p_w)
  );

  asnf32_fmul u_t (
    .clk, .ce({ce[4], ce[5]}),
    .a(p_w), .b(y0_r[3]), .result(t_w)
  );

  asnf32_fadd u_s (
    .clk, .ce({ce[6], ce[7]}),
    .a(asnf32_pkg::BITS_THREE_HALVES), .b({~t_w[31], t_w[30:0]}), .result(s_w)
  );

  asnf32_fmul u_y (
    .clk, .ce({ce[8], ce[9]}),
    .a(y0_r[7]), .b(s_w), .result(y_w)
  );

  asnf32_fmul u_r (
    .clk, .ce({ce[10], ce[11]}),
    .a(y_w), .b(x_r[9]), .result(r_w)
  );

  assign in_s.ready      = ce[0];
  assign out_s.valid     = valid_r[N-1];
  assign out_s.root_bits = r_w;

endmodule
